// File: src/upac_pkg.sv
package upac_pkg;

	// register indexes of the configuration port
	typedef enum logic [2:0] {
		CFG_MASS     = 3'd0,
		CFG_DAMPING  = 3'd1,
		CFG_PERIOD   = 3'd2,
		CFG_LOWER    = 3'd3,
		CFG_UPPER    = 3'd4,
		CFG_DAMPER   = 3'd5,
		CFG_LIMIT    = 3'd6,
		CFG_OBS_TICK = 3'd7
	} cfg_idx_t;

	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 32;

	// register values after reset
	localparam logic [30:0] MassRst    = 31'd15729;
	localparam logic [30:0] DampingRst = 31'd5243;
	localparam logic [16:0] PeriodRst  = 17'd66;
	localparam logic [31:0] LowerRst   = 32'd0;
	localparam logic [31:0] UpperRst   = 32'd13107;
	localparam logic [30:0] DamperRst  = 31'd1311;
	localparam logic [30:0] LimitRst   = 31'd6554;
	localparam logic [23:0] ObsTickRst = 24'd10000000;
	localparam logic [31:0] EnergyRst  = 32'd6554;

	// divider retires two quotient bits per cycle over a 64 bit dividend
	localparam int DivSteps = 32;
	localparam int DivCntW  = $clog2(DivSteps);

	typedef struct packed {
		logic signed [31:0] measured_velocity;
		logic signed [31:0] interaction_force;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] velocity_command;
		logic signed [31:0] energy_pred;
		logic               damper_active;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_TAKE,
		ST_DIV,
		ST_SAT,
		ST_OUT
	} state_t;

	// multiplier operations in the order they run
	typedef enum logic [3:0] {
		OP_FDT,
		OP_MV,
		OP_BDT,
		OP_VF,
		OP_VLO,
		OP_VHI,
		OP_WF,
		OP_WLO,
		OP_WHI,
		OP_CF
	} op_t;

endpackage

// File: src/upac_in_if.sv
interface upac_in_if;
	logic               valid;
	logic               ready;
	upac_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: src/upac_out_if.sv
interface upac_out_if;
	logic                valid;
	logic                ready;
	upac_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: src/ultimate_passivity_admittance_ctrl.sv
// Admittance controller with passivity observer and hysteresis damper, one axis.
// Channel meas takes one item per control tick: measured velocity and
// interaction force. Channel cmd returns one item per tick: velocity command,
// predicted observer energy and the damper flag. Both use valid/ready.
// Gains and thresholds sit on the cfg_we/cfg_index/cfg_data write port. The
// user must write them while no tick is in flight; the block does not enforce it.
// One 33x33 signed multiplier with a registered product runs ten products in
// turn (issue cycle then use cycle), and a restoring divider retires two
// quotient bits a cycle for the virtual velocity; the divider is skipped when
// the mass plus damping term is zero. meas.ready returns in the same cycle as
// the result is loaded into the output register.
// meas.ready is high only while the sequencer is idle. The result sits in an
// output register, so a new item is accepted while cmd is stalled; that item
// then waits in its last step until the register is free.
// Reset (arst_n low) loads the register defaults, sets stored energy to 0.1,
// clears the held admittance and tick count, and drops cmd.valid.
module ultimate_passivity_admittance_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	upac_in_if.sink                        meas,
	upac_out_if.source                     cmd,
	input  logic                           cfg_we,
	input  logic [upac_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [upac_pkg::CfgDataW-1:0]  cfg_data
);

	// configuration registers
	logic        [30:0] mass_q;
	logic        [30:0] damping_q;
	logic        [16:0] dt_q;
	logic signed [31:0] lower_q;
	logic signed [31:0] upper_q;
	logic        [30:0] damper_q;
	logic        [30:0] limit_q;
	logic        [23:0] obs_tick_q;

	// tick state
	logic signed [31:0] stored_q;
	logic signed [31:0] held_q;
	logic        [23:0] tick_q;

	// sequencer
	upac_pkg::state_t state_q, state_d;
	upac_pkg::op_t    op_q, op_d;
	logic [upac_pkg::DivCntW-1:0] div_cnt_q;
	logic             out_valid_q;

	// datapath
	logic signed [31:0] v_q, f_q;
	logic signed [65:0] prod_q;
	logic signed [63:0] acc_q;
	logic signed [63:0] num_q;
	logic        [32:0] den_q;
	logic        [63:0] dvd_q;
	logic        [32:0] rem_q;
	logic signed [31:0] vve_q;
	logic signed [47:0] p_q;
	logic signed [31:0] eobs_q;
	logic signed [31:0] pred_q;
	upac_pkg::out_item_t out_q;

	logic signed [32:0] mul_a, mul_b;
	logic        [32:0] den_d;
	logic        [63:0] num_abs;
	logic        [33:0] r1, r2;
	logic               ge1, ge2;
	logic        [32:0] r1n, r2n;
	logic        [63:0] d1;
	logic signed [63:0] hi_sum;
	logic signed [47:0] inc;
	logic signed [31:0] e_base;
	logic signed [48:0] e_sum;
	logic signed [31:0] e_sat;
	logic signed [31:0] c_new;
	logic signed [47:0] vdiss;
	logic signed [48:0] cmd_sum;
	logic signed [48:0] lim49;
	logic signed [48:0] cmd_clamp;
	logic               active;
	logic        [23:0] tick_inc;
	logic               out_fire;
	logic               in_fire;

	function automatic logic signed [31:0] sat49(input logic signed [48:0] x);
		if (x > 49'sh0_7FFF_FFFF) begin
			sat49 = 32'sh7FFF_FFFF;
		end else if (x < -49'sh0_8000_0000) begin
			sat49 = -32'sh8000_0000;
		end else begin
			sat49 = x[31:0];
		end
	endfunction

	assign in_fire  = meas.valid && meas.ready;
	assign out_fire = (state_q == upac_pkg::ST_OUT) && (!out_valid_q || cmd.ready);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op_q)
			upac_pkg::OP_FDT: begin
				mul_a = {f_q[31], f_q};
				mul_b = $signed({16'd0, dt_q});
			end
			upac_pkg::OP_MV: begin
				mul_a = $signed({2'b00, mass_q});
				mul_b = {v_q[31], v_q};
			end
			upac_pkg::OP_BDT: begin
				mul_a = $signed({2'b00, damping_q});
				mul_b = $signed({16'd0, dt_q});
			end
			upac_pkg::OP_VF: begin
				mul_a = {v_q[31], v_q};
				mul_b = {f_q[31], f_q};
			end
			upac_pkg::OP_WF: begin
				mul_a = {vve_q[31], vve_q};
				mul_b = {f_q[31], f_q};
			end
			upac_pkg::OP_VLO, upac_pkg::OP_WLO: begin
				mul_a = $signed({1'b0, p_q[31:0]});
				mul_b = $signed({16'd0, dt_q});
			end
			upac_pkg::OP_VHI, upac_pkg::OP_WHI: begin
				mul_a = {{17{p_q[47]}}, p_q[47:32]};
				mul_b = $signed({16'd0, dt_q});
			end
			upac_pkg::OP_CF: begin
				mul_a = {held_q[31], held_q};
				mul_b = {f_q[31], f_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// denominator and dividend magnitude
	assign den_d   = {2'b00, mass_q} + {1'b0, prod_q[47:16]};
	assign num_abs = num_q[63] ? 64'(-num_q) : 64'(num_q);

	// two restoring division steps
	assign r1  = {rem_q, dvd_q[63]};
	assign ge1 = r1 >= {1'b0, den_q};
	assign r1n = ge1 ? 33'(r1 - {1'b0, den_q}) : r1[32:0];
	assign d1  = {dvd_q[62:0], ge1};
	assign r2  = {r1n, d1[63]};
	assign ge2 = r2 >= {1'b0, den_q};
	assign r2n = ge2 ? 33'(r2 - {1'b0, den_q}) : r2[32:0];

	// energy increment and saturated sum
	assign hi_sum = acc_q + $signed({prod_q[31:0], 32'd0});
	assign inc    = hi_sum[63:16];
	assign e_base = (op_q == upac_pkg::OP_VHI) ? stored_q : eobs_q;
	assign e_sum  = {{17{e_base[31]}}, e_base} + {inc[47], inc};
	assign e_sat  = sat49(e_sum);

	// hysteresis on the predicted energy, lower threshold first
	always_comb begin
		if (e_sat <= lower_q) begin
			c_new = $signed({1'b0, damper_q});
		end else if (e_sat >= upper_q) begin
			c_new = '0;
		end else begin
			c_new = held_q;
		end
	end

	// command with dissipation and clamp
	assign vdiss   = prod_q[63:16];
	assign cmd_sum = {{17{vve_q[31]}}, vve_q} + {vdiss[47], vdiss};
	assign active  = (held_q != 0) && (f_q != 0);
	assign lim49   = $signed({18'd0, limit_q});
	always_comb begin
		cmd_clamp = cmd_sum;
		if (active) begin
			if (cmd_sum > lim49) begin
				cmd_clamp = lim49;
			end else if (cmd_sum < -lim49) begin
				cmd_clamp = -lim49;
			end
		end
	end

	assign tick_inc = tick_q + 24'd1;

	// next state
	always_comb begin
		state_d    = state_q;
		op_d       = op_q;
		meas.ready = (state_q == upac_pkg::ST_IDLE);
		case (state_q)
			upac_pkg::ST_IDLE: begin
				if (meas.valid) begin
					state_d = upac_pkg::ST_ISSUE;
					op_d    = upac_pkg::OP_FDT;
				end
			end
			upac_pkg::ST_ISSUE: begin
				state_d = upac_pkg::ST_TAKE;
			end
			upac_pkg::ST_TAKE: begin
				state_d = upac_pkg::ST_ISSUE;
				case (op_q)
					upac_pkg::OP_FDT: op_d = upac_pkg::OP_MV;
					upac_pkg::OP_MV:  op_d = upac_pkg::OP_BDT;
					upac_pkg::OP_BDT: begin
						op_d    = upac_pkg::OP_VF;
						state_d = (den_d == '0) ? upac_pkg::ST_SAT : upac_pkg::ST_DIV;
					end
					upac_pkg::OP_VF:  op_d = upac_pkg::OP_VLO;
					upac_pkg::OP_VLO: op_d = upac_pkg::OP_VHI;
					upac_pkg::OP_VHI: op_d = upac_pkg::OP_WF;
					upac_pkg::OP_WF:  op_d = upac_pkg::OP_WLO;
					upac_pkg::OP_WLO: op_d = upac_pkg::OP_WHI;
					upac_pkg::OP_WHI: op_d = upac_pkg::OP_CF;
					upac_pkg::OP_CF:  state_d = upac_pkg::ST_OUT;
					default:          state_d = upac_pkg::ST_IDLE;
				endcase
			end
			upac_pkg::ST_DIV: begin
				if (div_cnt_q == upac_pkg::DivCntW'(upac_pkg::DivSteps - 1)) begin
					state_d = upac_pkg::ST_SAT;
				end
			end
			upac_pkg::ST_SAT: begin
				state_d = upac_pkg::ST_ISSUE;
			end
			upac_pkg::ST_OUT: begin
				if (!out_valid_q || cmd.ready) begin
					state_d = upac_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = upac_pkg::ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= upac_pkg::ST_IDLE;
			op_q    <= upac_pkg::OP_FDT;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

	// configuration, tick state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q      <= upac_pkg::MassRst;
			damping_q   <= upac_pkg::DampingRst;
			dt_q        <= upac_pkg::PeriodRst;
			lower_q     <= upac_pkg::LowerRst;
			upper_q     <= upac_pkg::UpperRst;
			damper_q    <= upac_pkg::DamperRst;
			limit_q     <= upac_pkg::LimitRst;
			obs_tick_q  <= upac_pkg::ObsTickRst;
			stored_q    <= upac_pkg::EnergyRst;
			held_q      <= '0;
			tick_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					upac_pkg::CFG_MASS:     mass_q     <= cfg_data[30:0];
					upac_pkg::CFG_DAMPING:  damping_q  <= cfg_data[30:0];
					upac_pkg::CFG_PERIOD:   dt_q       <= cfg_data[16:0];
					upac_pkg::CFG_LOWER:    lower_q    <= cfg_data;
					upac_pkg::CFG_UPPER:    upper_q    <= cfg_data;
					upac_pkg::CFG_DAMPER:   damper_q   <= cfg_data[30:0];
					upac_pkg::CFG_LIMIT:    limit_q    <= cfg_data[30:0];
					upac_pkg::CFG_OBS_TICK: obs_tick_q <= cfg_data[23:0];
					default: ;
				endcase
			end
			// admittance latches once the prediction is known
			if (state_q == upac_pkg::ST_TAKE && op_q == upac_pkg::OP_WHI) begin
				held_q <= c_new;
			end
			// observer period bookkeeping at hand-off
			if (out_fire) begin
				if (tick_inc >= obs_tick_q) begin
					tick_q   <= '0;
					stored_q <= '0;
				end else begin
					tick_q   <= tick_inc;
					stored_q <= eobs_q;
				end
			end
			if (out_fire) begin
				out_valid_q <= 1'b1;
			end else if (cmd.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			v_q <= meas.data.measured_velocity;
			f_q <= meas.data.interaction_force;
		end
		case (state_q)
			upac_pkg::ST_ISSUE: begin
				prod_q <= mul_a * mul_b;
			end
			upac_pkg::ST_TAKE: begin
				case (op_q)
					upac_pkg::OP_FDT: acc_q <= prod_q[63:0];
					upac_pkg::OP_MV:  num_q <= acc_q + prod_q[63:0];
					upac_pkg::OP_BDT: begin
						den_q     <= den_d;
						dvd_q     <= num_abs;
						rem_q     <= '0;
						div_cnt_q <= '0;
					end
					upac_pkg::OP_VF, upac_pkg::OP_WF: p_q <= prod_q[63:16];
					upac_pkg::OP_VLO, upac_pkg::OP_WLO: acc_q <= prod_q[63:0];
					upac_pkg::OP_VHI: eobs_q <= e_sat;
					upac_pkg::OP_WHI: pred_q <= e_sat;
					default: ;
				endcase
			end
			upac_pkg::ST_DIV: begin
				rem_q     <= r2n;
				dvd_q     <= {d1[62:0], ge2};
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			upac_pkg::ST_SAT: begin
				// truncated quotient with sign restored and saturated
				if (den_q == '0) begin
					if (num_q > 0) begin
						vve_q <= 32'sh7FFF_FFFF;
					end else if (num_q < 0) begin
						vve_q <= -32'sh8000_0000;
					end else begin
						vve_q <= '0;
					end
				end else if (!num_q[63]) begin
					vve_q <= (dvd_q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(dvd_q[31:0]);
				end else begin
					vve_q <= (dvd_q > 64'h8000_0000) ? -32'sh8000_0000 : -$signed(dvd_q[31:0]);
				end
			end
			default: ;
		endcase
		if (out_fire) begin
			out_q.velocity_command <= sat49(cmd_clamp);
			out_q.energy_pred      <= pred_q;
			out_q.damper_active    <= active;
		end
	end

	assign cmd.valid = out_valid_q;
	assign cmd.data  = out_q;

	// an accepted item starts the multiply sequence at once
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == upac_pkg::ST_ISSUE && op_q == upac_pkg::OP_FDT))
		else $error("item accepted without starting the sequence");

	// a new result only comes from the hand-off step
	a_rose: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(cmd.valid) |-> $past(state_q == upac_pkg::ST_OUT))
		else $error("result valid without hand-off");

	// tick count moves only when a result is handed off
	a_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(tick_q) |-> $past(out_fire))
		else $error("tick count changed outside hand-off");

	// a damped command stays inside the velocity limit
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.data.damper_active) |->
		(cmd.data.velocity_command <= $signed({1'b0, limit_q}) &&
		 cmd.data.velocity_command >= -$signed({1'b0, limit_q})))
		else $error("damped command outside limit");

endmodule

// File: tb/sv/ultimate_passivity_admittance_ctrl_tb.sv
module ultimate_passivity_admittance_ctrl_tb;

	localparam int     DirRows    = 20;
	localparam int     Phases     = 14;
	localparam int     PhaseTicks = 130;
	localparam int     WatchLimit = 3000;
	localparam int     LongHold   = 400;
	localparam longint S32Max     = 64'sd2147483647;
	localparam longint S32Min     = -S32Max - 64'sd1;

	typedef struct {
		logic [31:0]         v;
		logic [31:0]         f;
		bit                  pin;
		upac_pkg::out_item_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [upac_pkg::CfgIdxW-1:0]  cfg_index;
	logic [upac_pkg::CfgDataW-1:0] cfg_data;

	upac_in_if  meas_if ();
	upac_out_if cmd_if ();

	ultimate_passivity_admittance_ctrl dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.meas      (meas_if),
		.cmd       (cmd_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// gains and thresholds as the block should hold them
	logic [30:0] gain_mass;
	logic [30:0] gain_damp;
	logic [16:0] gain_dt;
	int          thr_lo;
	int          thr_hi;
	logic [30:0] damp_adm;
	logic [30:0] vel_lim;
	logic [23:0] obs_len;

	// observer state
	int          energy;
	int          held_adm;
	logic [23:0] ticks;

	upac_pkg::out_item_t pending_cmds [$];
	int        mismatches   = 0;
	int        quiet_cycles = 0;
	int        max_stall    = 18;
	int        stall_hold   = 0;

	// first two rows after reset: zero motion keeps the initial energy
	dir_row_t dir_tab [DirRows] = '{
		'{32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0, 32'd6554, 1'b0}},
		'{32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0, 32'd6554, 1'b0}},
		'{32'h7FFF_FFFF, 32'h0000_0000, 1'b0, '{32'h0, 32'h0, 1'b0}},
		'{32'h8000_0000, 32'h0000_0000, 1'b0, '{32'h0, 32'h0, 1'b0}},
		'{32'h0000_0000, 32'h7FFF_FFFF, 1'b0, '{32'h0, 32'h0, 1'b0}},
		'{32'h0000_0000, 32'h8000_0000, 1'b0, '{32'h0, 32'h0, 1'b0}},
		'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '{32'h0, 32'h0, 1'b0}},
		'{32'h0000_0000, 32'h0000_0000, 1'b0, '{32'h0, 32'h0, 1'b0}},
		'{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '{32'h0, 32'h0, 1'b0}},
		'{32'h0000_0000, 32'h0000_0001, 1'b0, '{32'h0, 32'h0, 1'b0}},
		'{32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '{32'h0, 32'h0, 1'b0}},
		'{32'h0000_0001, 32'hFFFF_FFFF, 1'b0, '{32'h0, 32'h0, 1'b0}},
		'{32'hFFFF_FFFF, 32'h0000_0001, 1'b0, '{32'h0, 32'h0, 1'b0}},
		'{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '{32'h0, 32'h0, 1'b0}},
		'{32'h8000_0000, 32'h8000_0000, 1'b0, '{32'h0, 32'h0, 1'b0}},
		'{32'h0001_0000, 32'h0001_0000, 1'b0, '{32'h0, 32'h0, 1'b0}},
		'{32'hFFFF_8000, 32'h0002_0000, 1'b0, '{32'h0, 32'h0, 1'b0}},
		'{32'h0000_1000, 32'hFFFF_F000, 1'b0, '{32'h0, 32'h0, 1'b0}},
		'{32'h0000_0000, 32'h0000_0000, 1'b0, '{32'h0, 32'h0, 1'b0}},
		'{32'h7FFF_0000, 32'h0000_0001, 1'b0, '{32'h0, 32'h0, 1'b0}}
	};

	function automatic longint clip32(longint x);
		if (x > S32Max) return S32Max;
		if (x < S32Min) return S32Min;
		return x;
	endfunction

	// energy of one tick: floor(floor(a*f) * dt), both shifts floor
	function automatic longint energy_step(longint a, longint f);
		longint p;
		p = (a * f) >>> 16;
		return (p * longint'(gain_dt)) >>> 16;
	endfunction

	// one control tick: virtual velocity, observer, hysteresis, clamp
	function automatic upac_pkg::out_item_t admittance_tick(upac_pkg::in_item_t it);
		longint              v, f, m, num, den, vq, eobs, pred, c, cmd, lim;
		logic                active;
		upac_pkg::out_item_t r;
		v   = longint'(it.measured_velocity);
		f   = longint'(it.interaction_force);
		m   = longint'(gain_mass);
		num = f * longint'(gain_dt) + m * v;
		den = m + ((longint'(gain_damp) * longint'(gain_dt)) >>> 16);
		if (den == 0)
			vq = (num > 0) ? S32Max : ((num < 0) ? S32Min : 64'sd0);
		else
			vq = clip32(num / den);
		eobs = clip32(longint'(energy) + energy_step(v, f));
		pred = clip32(eobs + energy_step(vq, f));

		// lower threshold wins when both are met
		if (pred <= longint'(thr_lo))
			c = longint'(damp_adm);
		else if (pred >= longint'(thr_hi))
			c = 0;
		else
			c = longint'(held_adm);
		held_adm = int'(c);

		active = (c != 0) && (f != 0);
		cmd    = vq + ((c * f) >>> 16);
		lim    = longint'(vel_lim);
		if (active) begin
			if (cmd > lim) cmd = lim;
			if (cmd < -lim) cmd = -lim;
		end
		cmd = clip32(cmd);

		ticks = ticks + 24'd1;
		if (ticks >= obs_len) begin
			ticks  = '0;
			energy = 0;
		end else begin
			energy = int'(eobs);
		end

		r.velocity_command = 32'(cmd);
		r.energy_pred      = 32'(pred);
		r.damper_active    = active;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// one register write, tracked in the local copy
	task automatic write_reg(upac_pkg::cfg_idx_t idx, logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			upac_pkg::CFG_MASS:     gain_mass = val[30:0];
			upac_pkg::CFG_DAMPING:  gain_damp = val[30:0];
			upac_pkg::CFG_PERIOD:   gain_dt   = val[16:0];
			upac_pkg::CFG_LOWER:    thr_lo    = int'(val);
			upac_pkg::CFG_UPPER:    thr_hi    = int'(val);
			upac_pkg::CFG_DAMPER:   damp_adm  = val[30:0];
			upac_pkg::CFG_LIMIT:    vel_lim   = val[30:0];
			upac_pkg::CFG_OBS_TICK: obs_len   = val[23:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic program_gains(logic [31:0] m, logic [31:0] b, logic [31:0] dt,
			logic [31:0] lo, logic [31:0] hi, logic [31:0] c, logic [31:0] lim,
			logic [31:0] obs);
		write_reg(upac_pkg::CFG_MASS, m);
		write_reg(upac_pkg::CFG_DAMPING, b);
		write_reg(upac_pkg::CFG_PERIOD, dt);
		write_reg(upac_pkg::CFG_LOWER, lo);
		write_reg(upac_pkg::CFG_UPPER, hi);
		write_reg(upac_pkg::CFG_DAMPER, c);
		write_reg(upac_pkg::CFG_LIMIT, lim);
		write_reg(upac_pkg::CFG_OBS_TICK, obs);
		cfg_we <= 1'b0;
	endtask

	// offer one tick, predict it once the block takes it
	task automatic send_tick(upac_pkg::in_item_t it, int max_gap, bit pin,
			upac_pkg::out_item_t pinned);
		int                  gap;
		upac_pkg::out_item_t exp_cmd;
		gap = $urandom_range(max_gap);
		if (gap != 0) begin
			meas_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		meas_if.valid <= 1'b1;
		meas_if.data  <= it;
		do @(posedge clk); while (!meas_if.ready);
		exp_cmd = admittance_tick(it);
		pending_cmds.push_back(pin ? pinned : exp_cmd);
	endtask

	// stop offering and wait for every outstanding command
	task automatic drain_ticks();
		meas_if.valid <= 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// mixed magnitudes so the energy crosses the thresholds often
	function automatic logic [31:0] rand_q();
		case ($urandom_range(9))
			0: return 32'h0;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3: return $urandom_range(1) ? 32'h1 : 32'hFFFF_FFFF;
			4, 5, 6: return $urandom_range(32'h2_0000) - 32'h1_0000;
			7, 8: return $urandom_range(32'h200_0000) - 32'h100_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_gain();
		case ($urandom_range(7))
			5: return $urandom;
			6: return 32'h0;
			7: return 32'h7FFF_FFFF;
			default: return $urandom_range(32'h4_0000);
		endcase
	endfunction

	function automatic logic [31:0] rand_dt();
		case ($urandom_range(7))
			6: return $urandom;
			7: return 32'h1_0000;
			default: return $urandom_range(32'h1000, 1);
		endcase
	endfunction

	function automatic logic [31:0] rand_thr();
		case ($urandom_range(7))
			6: return $urandom;
			7: return 32'h0;
			default: return $urandom_range(32'h2_0000) - 32'h1_0000;
		endcase
	endfunction

	function automatic logic [31:0] rand_obs();
		case ($urandom_range(7))
			6: return $urandom;
			7: return 32'h0;
			default: return $urandom_range(40, 1);
		endcase
	endfunction

	// command sink with random stalls and one long hold on request
	initial begin : cmd_sink
		int n;
		cmd_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			n = (stall_hold != 0) ? stall_hold : $urandom_range(max_stall);
			stall_hold = 0;
			if (n != 0) begin
				cmd_if.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			cmd_if.ready <= 1'b1;
			do @(posedge clk); while (!cmd_if.valid);
		end
	end

	// compare each accepted command with the oldest prediction
	always @(posedge clk) begin : cmd_check
		upac_pkg::out_item_t want;
		if (arst_n && cmd_if.valid && cmd_if.ready) begin
			if (pending_cmds.size() == 0) begin
				report_mismatch("command with no tick pending", cmd_if.data.velocity_command,
					32'h0);
			end else begin
				want = pending_cmds.pop_front();
				if (cmd_if.data.velocity_command !== want.velocity_command)
					report_mismatch("velocity_command", cmd_if.data.velocity_command,
						want.velocity_command);
				if (cmd_if.data.energy_pred !== want.energy_pred)
					report_mismatch("energy_pred", cmd_if.data.energy_pred,
						want.energy_pred);
				if (cmd_if.data.damper_active !== want.damper_active)
					report_mismatch("damper_active", {31'b0, cmd_if.data.damper_active},
						{31'b0, want.damper_active});
			end
		end
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if (!arst_n || (meas_if.valid && meas_if.ready) || (cmd_if.valid && cmd_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WatchLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		upac_pkg::in_item_t  it;
		upac_pkg::out_item_t none;
		int                  phase_gap;
		none          = '0;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		meas_if.valid = 1'b0;
		meas_if.data  = '0;

		// reset values of the local copy
		gain_mass = upac_pkg::MassRst;
		gain_damp = upac_pkg::DampingRst;
		gain_dt   = upac_pkg::PeriodRst;
		thr_lo    = int'(upac_pkg::LowerRst);
		thr_hi    = int'(upac_pkg::UpperRst);
		damp_adm  = upac_pkg::DamperRst;
		vel_lim   = upac_pkg::LimitRst;
		obs_len   = upac_pkg::ObsTickRst;
		energy    = int'(upac_pkg::EnergyRst);
		held_adm  = 0;
		ticks     = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed ticks at reset gains
		for (int k = 0; k < DirRows; k++) begin
			it.measured_velocity = dir_tab[k].v;
			it.interaction_force = dir_tab[k].f;
			send_tick(it, (k < 10) ? 0 : 18, dir_tab[k].pin, dir_tab[k].want);
		end

		for (int p = 1; p <= Phases; p++) begin
			drain_ticks();
			case (p)
				// zero denominator, no damping
				1: program_gains(32'h0, 32'h0, 32'd66, 32'h0, 32'd13107, 32'd1311,
					32'd6554, 32'd10000000);
				// zero denominator with damping below one lsb, thresholds overlap
				2: program_gains(32'h0, 32'd500, 32'd66, 32'd5000, -32'd5000, 32'd70000,
					32'd20000, 32'd3);
				// every register at its top, lower threshold at its most negative
				3: program_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
					32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
				// smallest gains, zero period and limit
				4: program_gains(32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
				// back to the reset gains
				5: program_gains(32'(upac_pkg::MassRst), 32'(upac_pkg::DampingRst),
					32'(upac_pkg::PeriodRst), upac_pkg::LowerRst, upac_pkg::UpperRst,
					32'(upac_pkg::DamperRst), 32'(upac_pkg::LimitRst),
					32'(upac_pkg::ObsTickRst));
				default: program_gains(rand_gain(), rand_gain(), rand_dt(), rand_thr(),
					rand_thr(), rand_gain(), rand_gain(), rand_obs());
			endcase
			phase_gap = (p % 3 == 0) ? 0 : 18;
			max_stall = (p % 4 == 1) ? 0 : 18;
			// long sink hold with back to back ticks so the block backs up
			if (p == 5)
				stall_hold = LongHold;
			for (int k = 0; k < PhaseTicks; k++) begin
				it.measured_velocity = rand_q();
				it.interaction_force = rand_q();
				send_tick(it, (p == 5 && k < 12) ? 0 : phase_gap, 1'b0, none);
			end
		end

		drain_ticks();
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: ultimate_passivity_admittance_ctrl.f
src/upac_pkg.sv
src/upac_in_if.sv
src/upac_out_if.sv
src/ultimate_passivity_admittance_ctrl.sv
tb/sv/ultimate_passivity_admittance_ctrl_tb.sv
